[design/srph_pkg.sv]
`default_nettype none
// srph_pkg: request codes, register indexes, reset values and payload structs
// for the SRP hash Hamming top-k search. No dependencies.
package srph_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned MaxItemsDef = 1024;
  localparam int unsigned MaxDimsDef  = 16;
  localparam int unsigned KeyWordsDef = 2;
  localparam int unsigned ListMaxDef  = 64;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CFG_NUM_ITEMS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIMS      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIST_LEN  = 2'd2;

  localparam logic [10:0] NUM_ITEMS_RST = 11'd1024;
  localparam logic [4:0]  DIMS_RST      = 5'd16;
  localparam logic [6:0]  LIST_LEN_RST  = 7'd10;

  // request codes
  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_WEIGHT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         item_index;
    logic               word_index;
    logic [63:0]        key_word;
    logic [6:0]         proj_index;
    logic [3:0]         dim_index;
    logic signed [15:0] value;
    logic               query_last;
  } req_t;

  typedef struct packed {
    logic [9:0] cand_id;
    logic [7:0] score;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

[design/srph_proj.sv]
`default_nettype none
// srph_proj: weight and query memories and the multiply-accumulate sequencer
// that turns the query into its packed sign-bit key. No package dependency.
module srph_proj #(
  parameter int unsigned MAX_DIMS  = 16,
  parameter int unsigned KEY_WORDS = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wt_we_i,
  input  logic [6:0]                wt_proj_i,
  input  logic [3:0]                wt_dim_i,
  input  logic signed [15:0]        wt_val_i,
  input  logic                      q_we_i,
  input  logic [3:0]                q_dim_i,
  input  logic signed [15:0]        q_val_i,
  input  logic [4:0]                dims_i,
  input  logic                      start_i,
  output logic                      done_o,
  output logic [64*KEY_WORDS-1:0]   qkey_o
);

  localparam int unsigned NP  = 64 * KEY_WORDS;
  localparam int unsigned PW  = $clog2(NP);
  localparam int unsigned DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DIMS + 1);
  localparam int unsigned WD  = NP * MAX_DIMS;
  localparam int unsigned WAW = $clog2(WD);
  localparam int unsigned AW  = 32 + DCW;

  logic signed [15:0] wmem [WD];
  logic signed [15:0] qmem [MAX_DIMS];

  logic               wt_ok, q_ok;
  logic [WAW-1:0]     wt_waddr, w_raddr;
  logic [DW-1:0]      q_waddr;
  logic [DCW-1:0]     d_eff;
  logic signed [15:0] w_rd_q, q_rd_q;

  logic               run_q;
  logic [PW-1:0]      p_q;
  logic [DW-1:0]      i_q;
  logic               i_last, p_last;

  logic               s1_v_q, s1_end_q, s1_plast_q;
  logic [PW-1:0]      s1_p_q;
  logic               s2_v_q, s2_end_q, s2_plast_q;
  logic [PW-1:0]      s2_p_q;
  logic signed [31:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_sum;
  logic [NP-1:0]      qkey_q;
  logic               done_q;

  // load decode; out of range loads are dropped
  assign wt_ok    = wt_we_i && (32'(wt_proj_i) < NP) && (32'(wt_dim_i) < MAX_DIMS);
  assign q_ok     = q_we_i && (32'(q_dim_i) < MAX_DIMS);
  assign wt_waddr = WAW'(32'(wt_proj_i) * MAX_DIMS + 32'(wt_dim_i));
  assign q_waddr  = DW'(q_dim_i);
  assign d_eff    = (32'(dims_i) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_i);

  // sequencer position: projection p, dimension i
  assign i_last  = (DCW'(i_q) + DCW'(1)) == d_eff;
  assign p_last  = p_q == PW'(NP - 1);
  assign w_raddr = WAW'(32'(p_q) * MAX_DIMS + 32'(i_q));

  // memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wt_ok) begin
      wmem[wt_waddr] <= wt_val_i;
    end
    w_rd_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_ok) begin
      qmem[q_waddr] <= q_val_i;
    end
    q_rd_q <= qmem[i_q];
  end

  // product stage
  always_ff @(posedge clk_i) begin
    prod_q <= w_rd_q * q_rd_q;
  end

  assign acc_sum = acc_q + AW'(prod_q);

  // issue, pipeline tags, accumulate and sign-bit capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      p_q        <= '0;
      i_q        <= '0;
      s1_v_q     <= 1'b0;
      s1_end_q   <= 1'b0;
      s1_plast_q <= 1'b0;
      s1_p_q     <= '0;
      s2_v_q     <= 1'b0;
      s2_end_q   <= 1'b0;
      s2_plast_q <= 1'b0;
      s2_p_q     <= '0;
      acc_q      <= '0;
      qkey_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        p_q   <= '0;
        i_q   <= '0;
        acc_q <= '0;
        if (d_eff == '0) begin
          // no dimensions: every dot product is zero
          qkey_q <= '1;
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        if (i_last) begin
          i_q <= '0;
          p_q <= p_q + PW'(1);
          if (p_last) begin
            run_q <= 1'b0;
          end
        end else begin
          i_q <= i_q + DW'(1);
        end
      end
      s1_v_q     <= run_q && !start_i;
      s1_end_q   <= i_last;
      s1_plast_q <= p_last;
      s1_p_q     <= p_q;
      s2_v_q     <= s1_v_q;
      s2_end_q   <= s1_end_q;
      s2_plast_q <= s1_plast_q;
      s2_p_q     <= s1_p_q;
      if (s2_v_q) begin
        if (s2_end_q) begin
          // bit 63-j of word w holds projection 64w+j
          qkey_q[s2_p_q ^ PW'(63)] <= ~acc_sum[AW-1];
          acc_q                    <= '0;
          done_q                   <= s2_plast_q;
        end else begin
          acc_q <= acc_sum;
        end
      end
    end
  end

  assign done_o = done_q;
  assign qkey_o = qkey_q;

endmodule
`default_nettype wire

[design/srph_scan.sv]
`default_nettype none
// srph_scan: item key memory and the scan that scores each of the first num_items
// items against the query key by matching bit count. No package dependency.
module srph_scan #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned KEY_WORDS = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 key_we_i,
  input  logic [9:0]                           key_item_i,
  input  logic                                 key_word_i,
  input  logic [63:0]                          key_data_i,
  input  logic                                 start_i,
  input  logic [10:0]                          num_items_i,
  input  logic [64*KEY_WORDS-1:0]              qkey_i,
  output logic                                 ins_v_o,
  output logic [((MAX_ITEMS>1)?$clog2(MAX_ITEMS):1)-1:0] ins_id_o,
  output logic [$clog2(64*KEY_WORDS+1)-1:0]    ins_score_o,
  output logic                                 done_o
);

  localparam int unsigned NP  = 64 * KEY_WORDS;
  localparam int unsigned KD  = MAX_ITEMS * KEY_WORDS;
  localparam int unsigned KAW = (KD > 1) ? $clog2(KD) : 1;
  localparam int unsigned IDW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned ICW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned SCW = $clog2(NP + 1);

  function automatic logic [6:0] popcnt64(input logic [63:0] x);
    logic [6:0] c;
    c = '0;
    for (int b = 0; b < 64; b++) begin
      c = c + 7'(x[b]);
    end
    return c;
  endfunction

  logic [63:0]    kmem [KD];
  logic           key_ok;
  logic [KAW-1:0] key_waddr, raddr;
  logic [ICW-1:0] n_eff;

  logic           run_q;
  logic [IDW-1:0] it_q;
  logic [WW-1:0]  wd_q;
  logic           w_last, it_last;

  logic           s1_v_q, s1_wlast_q, s1_ilast_q;
  logic [WW-1:0]  s1_wd_q;
  logic [IDW-1:0] s1_id_q;
  logic [63:0]    kd_q, qword;
  logic [SCW-1:0] diff_q, diff_sum;

  logic           ins_v_q, ins_last_q, zero_q;
  logic [IDW-1:0] ins_id_q;
  logic [SCW-1:0] ins_score_q;

  assign key_ok    = key_we_i && (32'(key_item_i) < MAX_ITEMS)
                     && (32'(key_word_i) < KEY_WORDS);
  assign key_waddr = KAW'(32'(key_item_i) * KEY_WORDS + 32'(key_word_i));
  assign n_eff     = (32'(num_items_i) > MAX_ITEMS) ? ICW'(MAX_ITEMS) : ICW'(num_items_i);

  // scan position: item, key word
  assign w_last  = 32'(wd_q) == (KEY_WORDS - 1);
  assign it_last = (ICW'(it_q) + ICW'(1)) == n_eff;
  assign raddr   = KAW'(32'(it_q) * KEY_WORDS + 32'(wd_q));

  // key memory
  always_ff @(posedge clk_i) begin
    if (key_ok) begin
      kmem[key_waddr] <= key_data_i;
    end
    kd_q <= kmem[raddr];
  end

  // per-word mismatch count, summed over the key words of one item
  assign qword    = qkey_i[32'(s1_wd_q) * 64 +: 64];
  assign diff_sum = diff_q + SCW'(popcnt64(kd_q ^ qword));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      it_q        <= '0;
      wd_q        <= '0;
      s1_v_q      <= 1'b0;
      s1_wlast_q  <= 1'b0;
      s1_ilast_q  <= 1'b0;
      s1_wd_q     <= '0;
      s1_id_q     <= '0;
      diff_q      <= '0;
      ins_v_q     <= 1'b0;
      ins_last_q  <= 1'b0;
      ins_id_q    <= '0;
      ins_score_q <= '0;
      zero_q      <= 1'b0;
    end else begin
      zero_q <= 1'b0;
      if (start_i) begin
        it_q   <= '0;
        wd_q   <= '0;
        diff_q <= '0;
        if (n_eff == '0) begin
          zero_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        if (w_last) begin
          wd_q <= '0;
          it_q <= it_q + IDW'(1);
          if (it_last) begin
            run_q <= 1'b0;
          end
        end else begin
          wd_q <= wd_q + WW'(1);
        end
      end
      s1_v_q     <= run_q && !start_i;
      s1_wlast_q <= w_last;
      s1_ilast_q <= it_last;
      s1_wd_q    <= wd_q;
      s1_id_q    <= it_q;
      ins_v_q    <= 1'b0;
      if (s1_v_q) begin
        if (s1_wlast_q) begin
          ins_v_q     <= 1'b1;
          ins_last_q  <= s1_ilast_q;
          ins_id_q    <= s1_id_q;
          ins_score_q <= SCW'(NP) - diff_sum;
          diff_q      <= '0;
        end else begin
          diff_q <= diff_sum;
        end
      end
    end
  end

  assign ins_v_o     = ins_v_q;
  assign ins_id_o    = ins_id_q;
  assign ins_score_o = ins_score_q;
  assign done_o      = (ins_v_q && ins_last_q) || zero_q;

endmodule
`default_nettype wire

[design/srph_topk.sv]
`default_nettype none
// srph_topk: sorted best-candidates list as a row of compare-and-shift slots,
// with a head pop for draining. No package dependency.
module srph_topk #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned KEY_WORDS = 2,
  parameter int unsigned LIST_MAX  = 64
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           clear_i,
  input  logic                                           ins_v_i,
  input  logic [((MAX_ITEMS>1)?$clog2(MAX_ITEMS):1)-1:0] ins_id_i,
  input  logic [$clog2(64*KEY_WORDS+1)-1:0]              ins_score_i,
  input  logic [6:0]                                     cap_i,
  input  logic                                           pop_i,
  output logic [((MAX_ITEMS>1)?$clog2(MAX_ITEMS):1)-1:0] head_id_o,
  output logic [$clog2(64*KEY_WORDS+1)-1:0]              head_score_o,
  output logic [$clog2(LIST_MAX+1)-1:0]                  count_o
);

  localparam int unsigned IDW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned SCW = $clog2(64 * KEY_WORDS + 1);
  localparam int unsigned CW  = $clog2(LIST_MAX + 1);

  logic [IDW-1:0]      id_q [LIST_MAX];
  logic [SCW-1:0]      sc_q [LIST_MAX];
  logic [CW-1:0]       count_q, cap_eff;
  logic [LIST_MAX-1:0] ge;

  assign cap_eff = (32'(cap_i) > LIST_MAX) ? CW'(LIST_MAX) : CW'(cap_i);

  // slot j: keep if it beats or ties the new score, else take the new entry
  // or the neighbor above; pop moves everything one slot toward the head
  for (genvar j = 0; j < LIST_MAX; j++) begin : g_slot
    logic           take_new;
    logic [IDW-1:0] id_up, id_dn;
    logic [SCW-1:0] sc_up, sc_dn;

    assign ge[j] = (CW'(j) < count_q) && (sc_q[j] >= ins_score_i);

    if (j == 0) begin : g_first
      assign take_new = 1'b1;
      assign id_dn    = id_q[j];
      assign sc_dn    = sc_q[j];
    end else begin : g_rest
      assign take_new = ge[j-1];
      assign id_dn    = id_q[j-1];
      assign sc_dn    = sc_q[j-1];
    end

    if (j + 1 < LIST_MAX) begin : g_mid
      assign id_up = id_q[j+1];
      assign sc_up = sc_q[j+1];
    end else begin : g_tail
      assign id_up = id_q[j];
      assign sc_up = sc_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (pop_i) begin
        id_q[j] <= id_up;
        sc_q[j] <= sc_up;
      end else if (ins_v_i && (CW'(j) < cap_eff) && !ge[j]) begin
        id_q[j] <= take_new ? ins_id_i : id_dn;
        sc_q[j] <= take_new ? ins_score_i : sc_dn;
      end
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (pop_i) begin
      count_q <= count_q - CW'(1);
    end else if (ins_v_i && (count_q < cap_eff)) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign head_id_o    = id_q[0];
  assign head_score_o = sc_q[0];
  assign count_o      = count_q;

  a_no_ins_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && ins_v_i))
    else $error("insert and pop in the same cycle");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from an empty list");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_MAX))
    else $error("list fill count above its size");

endmodule
`default_nettype wire

[design/srp_hash_hamming_topk_top.sv]
`default_nettype none
// srp_hash_hamming_topk_top: top level of the SRP hash Hamming top-k search.
// Uses srph_pkg, srph_proj, srph_scan and srph_topk.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | in_req_i  (srph_pkg::req_t)
//  out     | output    | out_valid_o / out_stall_i| out_res_o (srph_pkg::res_t)
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// Loads and non-last query coordinates are accepted whenever the block is idle.
// A last coordinate stalls the input through the multiply-accumulate of every projection
// (skipped when dims is 0), then the key memory reads (skipped when num_items is 0),
// then one candidate result per cycle while out_stall_i is low, and a return to idle;
// dims and num_items are taken after saturation to MAX_DIMS and MAX_ITEMS.
// Reset is asynchronous, active low; the memories need no clearing.
module srp_hash_hamming_topk_top #(
  parameter int unsigned MAX_ITEMS = srph_pkg::MaxItemsDef,
  parameter int unsigned MAX_DIMS  = srph_pkg::MaxDimsDef,
  parameter int unsigned KEY_WORDS = srph_pkg::KeyWordsDef,
  parameter int unsigned LIST_MAX  = srph_pkg::ListMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  srph_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output srph_pkg::res_t                 out_res_o,
  input  logic                           cfg_we_i,
  input  logic [srph_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srph_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  import srph_pkg::*;

  localparam int unsigned NP  = 64 * KEY_WORDS;
  localparam int unsigned IDW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned SCW = $clog2(NP + 1);
  localparam int unsigned CW  = $clog2(LIST_MAX + 1);

  typedef enum logic [1:0] {S_IDLE, S_PROJ, S_SCAN, S_EMIT} state_e;

  state_e          state_q;
  logic            out_valid_q;
  res_t            out_q;
  logic [10:0]     num_items_q;
  logic [4:0]      dims_q;
  logic [6:0]      list_len_q;

  logic            in_acc, key_we, wt_we, q_we, q_start;
  logic            proj_done, scan_start, scan_done, out_free, pop;
  logic [NP-1:0]   qkey;
  logic            ins_v;
  logic [IDW-1:0]  ins_id, head_id;
  logic [SCW-1:0]  ins_score, head_score;
  logic [CW-1:0]   count;

  // request decode
  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign key_we  = in_acc && (in_req_i.req_type == REQ_KEY);
  assign wt_we   = in_acc && (in_req_i.req_type == REQ_WEIGHT);
  assign q_we    = in_acc && (in_req_i.req_type == REQ_QUERY);
  assign q_start = q_we && in_req_i.query_last;

  assign scan_start = (state_q == S_PROJ) && proj_done;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = (state_q == S_EMIT) && out_free && (count != '0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_items_q <= NUM_ITEMS_RST;
      dims_q      <= DIMS_RST;
      list_len_q  <= LIST_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_ITEMS: num_items_q <= cfg_wdata_i;
        CFG_DIMS:      dims_q      <= cfg_wdata_i[4:0];
        CFG_LIST_LEN:  list_len_q  <= cfg_wdata_i[6:0];
        default:       ;
      endcase
    end
  end

  srph_proj #(
    .MAX_DIMS  (MAX_DIMS),
    .KEY_WORDS (KEY_WORDS)
  ) u_proj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wt_we_i   (wt_we),
    .wt_proj_i (in_req_i.proj_index),
    .wt_dim_i  (in_req_i.dim_index),
    .wt_val_i  (in_req_i.value),
    .q_we_i    (q_we),
    .q_dim_i   (in_req_i.dim_index),
    .q_val_i   (in_req_i.value),
    .dims_i    (dims_q),
    .start_i   (q_start),
    .done_o    (proj_done),
    .qkey_o    (qkey)
  );

  srph_scan #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_WORDS (KEY_WORDS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_we_i    (key_we),
    .key_item_i  (in_req_i.item_index),
    .key_word_i  (in_req_i.word_index),
    .key_data_i  (in_req_i.key_word),
    .start_i     (scan_start),
    .num_items_i (num_items_q),
    .qkey_i      (qkey),
    .ins_v_o     (ins_v),
    .ins_id_o    (ins_id),
    .ins_score_o (ins_score),
    .done_o      (scan_done)
  );

  srph_topk #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_WORDS (KEY_WORDS),
    .LIST_MAX  (LIST_MAX)
  ) u_topk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_start),
    .ins_v_i      (ins_v),
    .ins_id_i     (ins_id),
    .ins_score_i  (ins_score),
    .cap_i        (list_len_q),
    .pop_i        (pop),
    .head_id_o    (head_id),
    .head_score_o (head_score),
    .count_o      (count)
  );

  // control sequence and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_start) state_q <= S_PROJ;
        end
        S_PROJ: begin
          if (proj_done) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (count != '0) begin
              out_valid_q   <= 1'b1;
              out_q.cand_id <= 10'(head_id);
              out_q.score   <= 8'(head_score);
              out_q.last    <= (count == CW'(1));
            end else begin
              out_valid_q <= 1'b0;
              state_q     <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_out_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EMIT))
    else $error("result shown outside the drain phase");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_res_o.last) |=> !out_valid_o)
    else $error("result after the flagged last candidate");

  a_proj_done_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proj_done |-> (state_q == S_PROJ))
    else $error("projection finished outside its phase");

endmodule
`default_nettype wire
